>>> src/version_marker_scanner_unit_assert.svh
// assertion macros for the version marker scanner unit
// expects clk and arst_n in the scope where a macro is used
`ifndef VERSION_MARKER_SCANNER_UNIT_ASSERT_SVH
`define VERSION_MARKER_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define VMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/vms_pkg.sv
// shared types, constants and byte classifiers for the version marker scanner
// no dependencies
package vms_pkg;

	// result record kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_TEXT  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam int MAX_RESULTS     = 4;
	localparam int QUEUE_DEPTH_DEF = 2;

	// bytes the scanner looks for
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_AT       = 8'b0000_0010,
		ST_AT_PAREN = 8'b0000_0100,
		ST_AT_HASH  = 8'b0000_1000,
		ST_PCT      = 8'b0001_0000,
		ST_PCT_LET  = 8'b0010_0000,
		ST_ENTRY    = 8'b0100_0000,
		ST_OWED_END = 8'b1000_0000
	} scan_state_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [1:0] record_kind;
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} rec_t;

	// all results caused by one input item
	typedef struct packed {
		logic [2:0]                   cnt;
		rec_t [MAX_RESULTS-1:0]       recs;
	} cmd_t;

	function automatic scan_state_t from_idle(logic [7:0] b, logic strict);
		scan_state_t s;
		s = ST_IDLE;
		if (b == CH_AT) s = ST_AT;
		else if (b == CH_PCT && !strict) s = ST_PCT;
		return s;
	endfunction

	function automatic logic is_text_byte(logic [7:0] b);
		logic t;
		t = ((b >= 8'h20) && (b <= 8'h7E)) || ((b >= 8'h09) && (b <= 8'h0D));
		if (b == CH_QUOTE || b == CH_BSLASH || b == CH_GT || b == CH_NL) t = 1'b0;
		return t;
	endfunction

endpackage

>>> src/vms_front.sv
// front part: scan state machine, classifies each byte into a result command
// depends on vms_pkg
module vms_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic            cfg_data,
	input  logic            in_valid,
	input  vms_pkg::in_item_t in_item,
	input  logic            q_full,
	output logic            push,
	output vms_pkg::cmd_t   push_cmd
);
	import vms_pkg::*;

	scan_state_t state_q;
	scan_state_t st_v;
	scan_state_t nxt;
	logic [7:0]  held_q;
	logic [7:0]  held_d;
	logic        strict_q;
	logic        accept;
	logic [7:0]  b;
	cmd_t        cmd;

	assign b      = in_item.in_byte;
	assign accept = in_valid && !q_full;

	always_comb begin
		st_v   = state_q;
		nxt    = state_q;
		held_d = held_q;
		cmd    = '0;
		// owed entry end goes out first, then byte is seen from idle
		if (st_v == ST_OWED_END) begin
			cmd.recs[cmd.cnt[1:0]] = '{kind: KIND_END, data: 8'h00};
			cmd.cnt = cmd.cnt + 3'd1;
			st_v = ST_IDLE;
		end
		case (st_v)
			ST_AT: begin
				nxt = (b == CH_LPAREN) ? ST_AT_PAREN : from_idle(b, strict_q);
			end
			ST_AT_PAREN: begin
				nxt = (b == CH_HASH) ? ST_AT_HASH : from_idle(b, strict_q);
			end
			ST_AT_HASH: begin
				if (b == CH_RPAREN) begin
					cmd.recs[cmd.cnt[1:0]] = '{kind: KIND_START, data: 8'h00};
					cmd.cnt = cmd.cnt + 3'd1;
					nxt = ST_ENTRY;
				end else begin
					nxt = from_idle(b, strict_q);
				end
			end
			ST_PCT: begin
				if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
					held_d = b;
					nxt = ST_PCT_LET;
				end else begin
					nxt = from_idle(b, strict_q);
				end
			end
			ST_PCT_LET: begin
				if (b == CH_PCT) begin
					// state was not owed, so the four slots are free
					cmd.recs[0] = '{kind: KIND_START, data: 8'h00};
					cmd.recs[1] = '{kind: KIND_TEXT, data: CH_PCT};
					cmd.recs[2] = '{kind: KIND_TEXT, data: held_q};
					cmd.recs[3] = '{kind: KIND_TEXT, data: CH_PCT};
					cmd.cnt = 3'd4;
					nxt = ST_ENTRY;
				end else begin
					nxt = from_idle(b, strict_q);
				end
			end
			ST_ENTRY: begin
				if (is_text_byte(b)) begin
					cmd.recs[cmd.cnt[1:0]] = '{kind: KIND_TEXT, data: b};
				end else begin
					cmd.recs[cmd.cnt[1:0]] = '{kind: KIND_END, data: 8'h00};
					nxt = ST_IDLE;
				end
				cmd.cnt = cmd.cnt + 3'd1;
			end
			default: begin
				nxt = from_idle(b, strict_q);
			end
		endcase
		if (in_item.end_of_file) begin
			if (nxt == ST_ENTRY) begin
				if (cmd.cnt < 3'd4) begin
					cmd.recs[cmd.cnt[1:0]] = '{kind: KIND_END, data: 8'h00};
					cmd.cnt = cmd.cnt + 3'd1;
					nxt = ST_IDLE;
				end else begin
					nxt = ST_OWED_END;
				end
			end else begin
				nxt = ST_IDLE;
			end
		end
	end

	assign push     = accept && (cmd.cnt != 3'd0);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			held_q   <= 8'h00;
			strict_q <= 1'b0;
		end else begin
			if (cfg_valid) strict_q <= cfg_data;
			if (accept) begin
				state_q <= nxt;
				held_q  <= held_d;
			end
		end
	end

endmodule

>>> src/vms_queue.sv
// command queue between front and back parts, register based
// depends on vms_pkg and the assertion macro header
`include "version_marker_scanner_unit_assert.svh"

module vms_queue #(
	parameter int DEPTH = vms_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vms_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output vms_pkg::cmd_t head
);
	import vms_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`VMS_ASSERT_NOW(a_no_push_full, full, !push, "push into full queue")
	`VMS_ASSERT_NOW(a_no_pop_empty, empty, !pop, "pop from empty queue")
	`VMS_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CW'(DEPTH), "queue count out of range")
	`VMS_ASSERT_NOW(a_push_nonempty, push, push_cmd.cnt != 3'd0, "empty command queued")

endmodule

>>> src/vms_back.sv
// back part: one head result per unstalled cycle into the output register
// depends on vms_pkg
module vms_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  vms_pkg::cmd_t      head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output vms_pkg::out_item_t out_item
);
	import vms_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       load;
	logic       last;
	rec_t       rec;

	assign load = !empty && (!out_valid_q || !out_stall);
	assign rec  = head.recs[idx_q];
	assign last = ({1'b0, idx_q} == (head.cnt - 3'd1));
	assign pop  = load && last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.record_kind <= rec.kind;
			out_q.out_byte    <= rec.data;
			out_q.last_of_run <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> src/version_marker_scanner_unit.sv
// top level of the version marker scanner: front scanner, command queue, back emitter
// depends on vms_pkg, vms_front, vms_queue, vms_back
//
// usage
// - input channel: one file byte per item (in_item.in_byte) with an end of file flag,
//   taken at a clock edge with in_valid high and in_stall low
// - output channel: result records (entry start, text byte, entry end) with
//   last_of_run marking the final record caused by one input byte; taken at a
//   clock edge with out_valid high and out_stall low
// - config channel: cfg_data is the strict mode bit, written whenever cfg_valid
//   is high (cfg_ready is tied high); write it only while the block is idle
// - a byte's records are written into the command queue as the byte is taken,
//   then walked one by one into the output register
// - throughput: one byte per cycle while bytes cause at most one record each and the
//   receiver does not stall; a byte that causes n records holds the emitter until
//   all n are out, the queue of QUEUE_DEPTH commands absorbs bursts, then in_stall rises
// - bytes that cause no record never enter the queue
// - a stalled receiver freezes the output register; the scanner keeps taking
//   bytes until the queue is full
// - reset clears scan state, strict mode, queue and output valid; no clearing pass
module version_marker_scanner_unit #(
	parameter int QUEUE_DEPTH = vms_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  vms_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output vms_pkg::out_item_t out_item
);
	import vms_pkg::*;

	// front to queue
	logic  push;
	cmd_t  push_cmd;
	logic  q_full;
	// queue to back
	logic  q_empty;
	cmd_t  q_head;
	logic  pop;

	// config writes are always accepted
	assign cfg_ready = 1'b1;
	// scanner stalls only when the queue has no room
	assign in_stall  = q_full;

	vms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_item  (in_item),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	vms_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (q_head)
	);

	vms_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (q_head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

>>> tb/version_marker_scanner_checker.sv
// result checker for the version marker scanner: tracks the scan state per taken byte
// and compares every taken result record against the expected records
// depends on vms_pkg
module version_marker_scanner_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  vms_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_stall,
	input  vms_pkg::out_item_t out_item,
	output int                 mismatches,
	output int                 outstanding,
	output int                 bytes_taken,
	output int                 records_taken,
	output int                 entries_opened
);
	import vms_pkg::*;

	scan_state_t scan_st;
	logic [7:0]  held_letter;
	logic        strict_on;
	out_item_t   expected_q[$];

	// where a byte leads when nothing is pending
	function automatic scan_state_t restart(input logic [7:0] b);
		restart = ST_IDLE;
		if (b == CH_AT)
			restart = ST_AT;
		else if (b == CH_PCT && !strict_on)
			restart = ST_PCT;
	endfunction

	function automatic logic passes_as_text(input logic [7:0] b);
		if (b == CH_QUOTE || b == CH_BSLASH || b == CH_GT || b == CH_NL)
			passes_as_text = 1'b0;
		else
			passes_as_text = (b >= 8'h20 && b <= 8'h7E) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic out_item_t make_record(input logic [1:0] k, input logic [7:0] d);
		make_record = {k, d, 1'b0};
	endfunction

	task automatic predict_byte(input logic [7:0] b, input logic eof);
		out_item_t   recs [MAX_RESULTS];
		int          n;
		int          i;
		scan_state_t st;
		n = 0;
		st = scan_st;
		// entry end left over from a full step goes first
		if (st == ST_OWED_END) begin
			recs[n] = make_record(KIND_END, 8'h00);
			n++;
			st = ST_IDLE;
		end
		case (st)
			ST_AT: st = (b == CH_LPAREN) ? ST_AT_PAREN : restart(b);
			ST_AT_PAREN: st = (b == CH_HASH) ? ST_AT_HASH : restart(b);
			ST_AT_HASH: begin
				if (b == CH_RPAREN) begin
					recs[n] = make_record(KIND_START, 8'h00);
					n++;
					st = ST_ENTRY;
				end else begin
					st = restart(b);
				end
			end
			ST_PCT: begin
				if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
					held_letter = b;
					st = ST_PCT_LET;
				end else begin
					st = restart(b);
				end
			end
			ST_PCT_LET: begin
				if (b == CH_PCT) begin
					recs[0] = make_record(KIND_START, 8'h00);
					recs[1] = make_record(KIND_TEXT, CH_PCT);
					recs[2] = make_record(KIND_TEXT, held_letter);
					recs[3] = make_record(KIND_TEXT, CH_PCT);
					n = 4;
					st = ST_ENTRY;
				end else begin
					st = restart(b);
				end
			end
			ST_ENTRY: begin
				if (passes_as_text(b)) begin
					recs[n] = make_record(KIND_TEXT, b);
					n++;
				end else begin
					recs[n] = make_record(KIND_END, 8'h00);
					n++;
					st = ST_IDLE;
				end
			end
			default: st = restart(b);
		endcase
		if (eof) begin
			if (st == ST_ENTRY) begin
				if (n < MAX_RESULTS) begin
					recs[n] = make_record(KIND_END, 8'h00);
					n++;
					st = ST_IDLE;
				end else begin
					st = ST_OWED_END;
				end
			end else begin
				st = ST_IDLE;
			end
		end
		scan_st = st;
		for (i = 0; i < n; i++) begin
			if (i == n - 1)
				recs[i].last_of_run = 1'b1;
			if (recs[i].record_kind == KIND_START)
				entries_opened++;
			expected_q.push_back(recs[i]);
		end
	endtask

	task automatic check_record(input out_item_t got);
		out_item_t want;
		records_taken++;
		if (expected_q.size() == 0) begin
			$error("unexpected record: record_kind %0d out_byte %h last_of_run %0d",
				got.record_kind, got.out_byte, got.last_of_run);
			mismatches++;
		end else begin
			want = expected_q.pop_front();
			if (got.record_kind !== want.record_kind) begin
				$error("record_kind: expected %0d, got %0d", want.record_kind, got.record_kind);
				mismatches++;
			end
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
				mismatches++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_st = ST_IDLE;
			held_letter = 8'h00;
			strict_on = 1'b0;
			expected_q.delete();
			mismatches = 0;
			outstanding = 0;
			bytes_taken = 0;
			records_taken = 0;
			entries_opened = 0;
		end else begin
			if (out_valid && !out_stall)
				check_record(out_item);
			if (cfg_valid && cfg_ready)
				strict_on = cfg_data;
			if (in_valid && !in_stall) begin
				bytes_taken++;
				predict_byte(in_item.in_byte, in_item.end_of_file);
			end
			outstanding = expected_q.size();
		end
	end

endmodule

>>> tb/tb_version_marker_scanner_unit.sv
// testbench top for the version marker scanner unit: drives file bytes, strict mode
// writes and receiver stalls; the checker beside the block predicts and compares
// depends on vms_pkg, version_marker_scanner_unit and version_marker_scanner_checker
module tb_version_marker_scanner_unit;
	import vms_pkg::*;

	// cycles with no handshake at all before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	// margin left after every expected record is out
	localparam int PIPE_SLACK     = 4;
	localparam int DRAIN_CYCLES   = 10;
	// long receiver hold-off, well past what the queue can absorb
	localparam int HOLD_CYCLES    = 120;
	localparam int PHASE_BYTES    = 32;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	int mismatches;
	int outstanding;
	int bytes_taken;
	int records_taken;
	int entries_opened;

	// idle odds in percent per cycle for each side
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// long hold requests from stimulus, served by the receiver process
	int long_holds_asked = 0;
	int long_holds_done = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int phase_start;

	version_marker_scanner_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	version_marker_scanner_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_item       (out_item),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.bytes_taken    (bytes_taken),
		.records_taken  (records_taken),
		.entries_opened (entries_opened)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver side: random stall, or a long hold when stimulus asks for one
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (long_holds_done != long_holds_asked) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			long_holds_done <= long_holds_done + 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one byte, holding it until taken; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic eof);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= {b, eof};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// drop valid and wait until every expected record is out, plus pipeline slack
	task automatic settle();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (PIPE_SLACK) @(negedge clk);
	endtask

	task automatic write_strict(input logic v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly text, with the edges of both text ranges
	function automatic logic [7:0] pick_text();
		case ($urandom_range(9))
			0: pick_text = 8'h09;
			1: pick_text = 8'h0D;
			2: pick_text = 8'h20;
			3: pick_text = 8'h7E;
			default: pick_text = 8'($urandom_range(8'h20, 8'h7E));
		endcase
	endfunction

	// every kind of byte that closes an entry
	function automatic logic [7:0] pick_stop();
		case ($urandom_range(9))
			0: pick_stop = 8'h00;
			1: pick_stop = CH_QUOTE;
			2: pick_stop = CH_BSLASH;
			3: pick_stop = CH_GT;
			4: pick_stop = CH_NL;
			5: pick_stop = 8'h7F;
			6: pick_stop = 8'($urandom_range(8'h00, 8'h08));
			7: pick_stop = 8'($urandom_range(8'h0E, 8'h1F));
			default: pick_stop = 8'($urandom_range(8'h80, 8'hFF));
		endcase
	endfunction

	// entry body: some text, then a terminator or end of file
	task automatic close_entry();
		int len;
		int i;
		len = $urandom_range(0, 6);
		for (i = 0; i < len; i++)
			send_byte(pick_text(), 1'b0);
		if ($urandom_range(4) == 0)
			send_byte(pick_text(), 1'b1);
		else
			send_byte(pick_stop(), $urandom_range(7) == 0);
	endtask

	// one random stretch of file: well-formed entries mostly, broken ones and noise
	task automatic send_fragment();
		int sel;
		int i;
		int reps;
		string marker;
		sel = $urandom_range(99);
		marker = "@(#";
		if (sel < 40) begin
			send_text(marker);
			if ($urandom_range(9) == 0) begin
				// end of file right on the marker
				send_byte(CH_RPAREN, 1'b1);
			end else begin
				send_byte(CH_RPAREN, 1'b0);
				close_entry();
			end
		end else if (sel < 65) begin
			send_byte(CH_PCT, 1'b0);
			send_byte(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)), 1'b0);
			if ($urandom_range(5) == 0) begin
				// all four slots full, the entry end carries over
				send_byte(CH_PCT, 1'b1);
			end else begin
				send_byte(CH_PCT, 1'b0);
				close_entry();
			end
		end else if (sel < 80) begin
			// broken prefix, the odd byte gets a fresh look
			if ($urandom_range(1) == 0) begin
				reps = $urandom_range(1, 3);
				for (i = 0; i < reps; i++)
					send_byte(marker[i], 1'b0);
			end else begin
				send_byte(CH_PCT, 1'b0);
				if ($urandom_range(1) == 0)
					send_byte(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)), 1'b0);
			end
			send_byte(8'($urandom_range(8'h00, 8'hFF)), $urandom_range(7) == 0);
		end else begin
			reps = $urandom_range(1, 4);
			for (i = 0; i < reps; i++)
				send_byte(8'($urandom_range(8'h00, 8'hFF)), $urandom_range(7) == 0);
		end
	endtask

	task automatic random_phase(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct <= receiver_pct;
		phase_start = bytes_taken;
		while (bytes_taken - phase_start < PHASE_BYTES)
			send_fragment();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first idle pattern, relaxed mode written explicitly
		send_idle_pct = 20;
		recv_idle_pct <= 52;
		write_strict(1'b0);

		// marker entry with the text range edges, closed by a nul
		send_text("@(#)");
		send_byte(8'h09, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'h00, 1'b0);
		// repeated at sign and a percent that breaks the marker, then a keyword
		send_text("@@(%A%");
		send_byte(CH_GT, 1'b0);
		// end of file on the closing percent, the entry end is owed
		send_text("%Z");
		send_byte(CH_PCT, 1'b1);
		// owed end comes first, then the at sign starts a new match
		send_text("@(#)");
		send_byte(8'h20, 1'b0);
		// end of file inside an entry
		send_byte(8'h0D, 1'b1);
		send_byte(8'hFF, 1'b0);

		// strict mode switched on while a percent match is under way
		send_byte(CH_PCT, 1'b0);
		settle();
		write_strict(1'b1);
		send_text("B%x");
		send_byte(CH_NL, 1'b0);
		// under strict mode the keyword form is plain noise
		send_text("%C%");
		send_byte(CH_NL, 1'b1);

		// random part, relaxed mode with the first idle pattern
		settle();
		write_strict(1'b0);
		random_phase(20, 52);

		// strict mode with the idle pattern turned around
		settle();
		write_strict(1'b1);
		random_phase(52, 20);

		// relaxed mode, no idling on either side
		settle();
		write_strict(1'b0);
		random_phase(0, 0);

		// receiver holds off while a long entry keeps coming: queue fills, input stalls
		long_holds_asked <= long_holds_asked + 1;
		send_text("@(#)");
		repeat (24) send_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
		send_byte(CH_QUOTE, 1'b0);

		// drain and let any stray record show up
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run: %0d bytes scanned, %0d records checked, %0d entries opened",
			bytes_taken, records_taken, entries_opened);
		$display("both strict settings, idling on either side, a long receiver hold-off");
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
